FILE: hw/rtl/tfnc_pkg.sv
// Shared types, constants and helpers for the triangle face normal/centroid block.
// Used by tfnc_ram users and the top level; no dependencies.
package tfnc_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int VERT_AW      = $clog2(VERTEX_DEPTH);
  localparam int VERT_W       = 96;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FACE  = 1'b1;

  // ceil(2^36 / 3); exact for dividends below 2^34
  localparam logic [34:0] DIV3_RECIP = 35'h5_5555_5556;

  localparam int MAG_W     = 30;
  localparam int SQ_W      = 64;
  localparam int SQ_STEPS  = 32;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = SQ_STEPS / SQ_PER;
  localparam int NRM_W     = 31;
  localparam int NUM_W     = 45;
  localparam int REM_W     = 47;
  localparam int DV_BITS   = 16;
  localparam int DV_PER    = 2;
  localparam int DV_STAGES = DV_BITS / DV_PER;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  vert_slot;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [9:0]  corner_a;
    logic [9:0]  corner_b;
    logic [9:0]  corner_c;
    logic        final_face;
  } in_item_t;

  typedef struct packed {
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic        degenerate;
    logic        final_face_out;
  } out_item_t;

  // per-item data riding along the square root and divide pipelines
  typedef struct packed {
    logic                  final_face;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0][31:0]      center;
  } side_t;

  function automatic logic [VERT_AW-1:0] vaddr(input logic [9:0] idx);
    return VERT_AW'(idx);
  endfunction

endpackage

FILE: hw/rtl/tfnc_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module tfnc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/triangle_face_normal_centroid.sv
// Top level: vertex store plus face normal / centroid pipeline.
// Depends on tfnc_pkg and tfnc_ram.
//
// Vertex write items (cmd 0) fill a 1024-entry store of Q16.16 vertices and give no
// result; face items (cmd 1) give one result each: a Q1.14 unit normal, the Q16.16
// centroid and a degenerate flag for a zero cross product. One item is taken every
// cycle while in_stall is low; a face result passes the 16-stage square root and the
// 8-stage divider, each resolving two result bits per stage. A face may use a vertex
// written by the item just before it. in_stall follows out_stall whenever a result is
// waiting, and the whole pipeline holds in place.
module triangle_face_normal_centroid
  import tfnc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic pipe_en;
  logic in_acc;
  logic wr_en;

  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;
  assign in_acc   = in_valid && pipe_en;
  assign wr_en    = in_acc && (in_data.cmd == CMD_WRITE)
                    && (32'(in_data.vert_slot) < VERTEX_DEPTH);

  // ---------------- stage 1: store read ----------------
  logic [VERT_W-1:0] rd_a, rd_b, rd_c;
  logic              s1_vld_r, s1_final_r;
  logic [2:0]        s1_zero_r;

  tfnc_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_DEPTH)) u_ram_a (
    .clk, .we(wr_en), .waddr(vaddr(in_data.vert_slot)),
    .wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .re(pipe_en), .raddr(vaddr(in_data.corner_a)), .rdata(rd_a)
  );
  tfnc_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_DEPTH)) u_ram_b (
    .clk, .we(wr_en), .waddr(vaddr(in_data.vert_slot)),
    .wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .re(pipe_en), .raddr(vaddr(in_data.corner_b)), .rdata(rd_b)
  );
  tfnc_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_DEPTH)) u_ram_c (
    .clk, .we(wr_en), .waddr(vaddr(in_data.vert_slot)),
    .wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .re(pipe_en), .raddr(vaddr(in_data.corner_c)), .rdata(rd_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r <= in_acc && (in_data.cmd == CMD_FACE);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_final_r   <= in_data.final_face;
      s1_zero_r[0] <= 32'(in_data.corner_a) >= VERTEX_DEPTH;
      s1_zero_r[1] <= 32'(in_data.corner_b) >= VERTEX_DEPTH;
      s1_zero_r[2] <= 32'(in_data.corner_c) >= VERTEX_DEPTH;
    end
  end

  // ---------------- stage 2: differences and sums ----------------
  logic [31:0] va [3];
  logic [31:0] vb [3];
  logic [31:0] vc [3];
  logic signed [32:0] s2_d0_r [3];
  logic signed [32:0] s2_d1_r [3];
  logic signed [33:0] s2_sum_r [3];
  logic               s2_vld_r, s2_final_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = s1_zero_r[0] ? 32'd0 : rd_a[VERT_W-1-32*i -: 32];
      vb[i] = s1_zero_r[1] ? 32'd0 : rd_b[VERT_W-1-32*i -: 32];
      vc[i] = s1_zero_r[2] ? 32'd0 : rd_c[VERT_W-1-32*i -: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_final_r <= s1_final_r;
      for (int i = 0; i < 3; i++) begin
        s2_d0_r[i]  <= $signed({va[i][31], va[i]}) - $signed({vc[i][31], vc[i]});
        s2_d1_r[i]  <= $signed({vb[i][31], vb[i]}) - $signed({vc[i][31], vc[i]});
        s2_sum_r[i] <= $signed({{2{va[i][31]}}, va[i]}) + $signed({{2{vb[i][31]}}, vb[i]})
                       + $signed({{2{vc[i][31]}}, vc[i]});
      end
    end
  end

  // ---------------- stage 3: products, centroid partial products ----------------
  logic signed [65:0] s3_pa_r [3];
  logic signed [65:0] s3_pb_r [3];
  logic [51:0]        s3_cl_r [3];
  logic [51:0]        s3_ch_r [3];
  logic [2:0]         s3_cneg_r;
  logic               s3_vld_r, s3_final_r;
  logic [33:0]        cmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = s2_sum_r[i][33] ? 34'(-s2_sum_r[i]) + 34'd1 : 34'(s2_sum_r[i]) + 34'd1;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_cross
    localparam int J1 = (g + 1) % 3;
    localparam int J2 = (g + 2) % 3;
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        s3_pa_r[g]   <= s2_d0_r[J1] * s2_d1_r[J2];
        s3_pb_r[g]   <= s2_d0_r[J2] * s2_d1_r[J1];
        s3_cl_r[g]   <= {17'd0, cmag[g][16:0]} * DIV3_RECIP;
        s3_ch_r[g]   <= {17'd0, cmag[g][33:17]} * DIV3_RECIP;
        s3_cneg_r[g] <= s2_sum_r[g][33];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_final_r <= s2_final_r;
    end
  end

  // ---------------- stage 4: cross product, centroid ----------------
  logic signed [66:0] s4_n_r [3];
  logic [31:0]        s4_center_r [3];
  logic               s4_vld_r, s4_final_r;
  logic [68:0]        cfull [3];
  logic [31:0]        cq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfull[i] = {s3_ch_r[i], 17'd0} + 69'(s3_cl_r[i]);
      cq[i]    = cfull[i][67:36];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_final_r <= s3_final_r;
      for (int i = 0; i < 3; i++) begin
        s4_n_r[i]      <= $signed({s3_pa_r[i][65], s3_pa_r[i]})
                          - $signed({s3_pb_r[i][65], s3_pb_r[i]});
        s4_center_r[i] <= s3_cneg_r[i] ? -cq[i] : cq[i];
      end
    end
  end

  // ---------------- stage 5: magnitudes ----------------
  logic [65:0] s5_mag_r [3];
  logic [65:0] s5_or_r;
  logic [2:0]  s5_neg_r;
  logic [31:0] s5_center_r [3];
  logic        s5_vld_r, s5_final_r;
  logic [65:0] mag5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag5[i] = s4_n_r[i][66] ? 66'(-s4_n_r[i]) : 66'(s4_n_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s5_final_r <= s4_final_r;
      s5_or_r    <= mag5[0] | mag5[1] | mag5[2];
      for (int i = 0; i < 3; i++) begin
        s5_mag_r[i]    <= mag5[i];
        s5_neg_r[i]    <= s4_n_r[i][66];
        s5_center_r[i] <= s4_center_r[i];
      end
    end
  end

  // ---------------- stage 6: leading one, shift amount ----------------
  logic [65:0] s6_mag_r [3];
  logic [6:0]  s6_sh_r;
  logic        s6_degen_r;
  logic [2:0]  s6_neg_r;
  logic [31:0] s6_center_r [3];
  logic        s6_vld_r, s6_final_r;
  logic [6:0]  blen;

  always_comb begin
    blen = 7'd0;
    for (int i = 0; i < 66; i++) begin
      if (s5_or_r[i]) begin
        blen = 7'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s6_final_r <= s5_final_r;
      s6_degen_r <= (blen == 7'd0);
      s6_sh_r    <= (blen > 7'(MAG_W)) ? blen - 7'(MAG_W) : 7'd0;
      s6_neg_r   <= s5_neg_r;
      for (int i = 0; i < 3; i++) begin
        s6_mag_r[i]    <= s5_mag_r[i];
        s6_center_r[i] <= s5_center_r[i];
      end
    end
  end

  // ---------------- stage 7: reduce to 30 bits ----------------
  logic [MAG_W-1:0] s7_m_r [3];
  logic             s7_degen_r;
  logic [2:0]       s7_neg_r;
  logic [31:0]      s7_center_r [3];
  logic             s7_vld_r, s7_final_r;
  logic [65:0]      shv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shv[i] = s6_mag_r[i] >> s6_sh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s7_final_r <= s6_final_r;
      s7_degen_r <= s6_degen_r;
      s7_neg_r   <= s6_neg_r;
      for (int i = 0; i < 3; i++) begin
        s7_m_r[i]      <= shv[i][MAG_W-1:0];
        s7_center_r[i] <= s6_center_r[i];
      end
    end
  end

  // ---------------- stage 8: squares ----------------
  logic [59:0] s8_sq_r [3];
  side_t       s8_sd_r;
  logic        s8_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s8_sd_r.final_face <= s7_final_r;
      s8_sd_r.degen      <= s7_degen_r;
      s8_sd_r.neg        <= s7_neg_r;
      for (int i = 0; i < 3; i++) begin
        s8_sq_r[i]        <= s7_m_r[i] * s7_m_r[i];
        s8_sd_r.mag[i]    <= s7_m_r[i];
        s8_sd_r.center[i] <= s7_center_r[i];
      end
    end
  end

  // ---------------- stage 9 and square root pipeline ----------------
  logic [SQ_W-1:0] sq_v_r [SQ_STAGES+1];
  logic [SQ_W-1:0] sq_r_r [SQ_STAGES+1];
  side_t           sq_sd_r [SQ_STAGES+1];
  logic            sq_vld_r [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      sq_vld_r[0] <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_v_r[0]  <= SQ_W'(s8_sq_r[0]) + SQ_W'(s8_sq_r[1]) + SQ_W'(s8_sq_r[2]);
      sq_r_r[0]  <= '0;
      sq_sd_r[0] <= s8_sd_r;
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    logic [SQ_W-1:0] v_nxt, r_nxt;

    always_comb begin
      logic [SQ_W-1:0] bv;
      v_nxt = sq_v_r[g];
      r_nxt = sq_r_r[g];
      for (int s = 0; s < SQ_PER; s++) begin
        bv = SQ_W'(1) << (2 * (SQ_STEPS - 1 - (g * SQ_PER + s)));
        if (v_nxt >= r_nxt + bv) begin
          v_nxt = v_nxt - (r_nxt + bv);
          r_nxt = (r_nxt >> 1) + bv;
        end else begin
          r_nxt = r_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[g+1] <= 1'b0;
      end else if (pipe_en) begin
        sq_vld_r[g+1] <= sq_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_v_r[g+1]  <= v_nxt;
        sq_r_r[g+1]  <= r_nxt;
        sq_sd_r[g+1] <= sq_sd_r[g];
      end
    end
  end

  // ---------------- divider pipeline ----------------
  logic [REM_W-1:0]   dv_rem_r [DV_STAGES+1][3];
  logic [DV_BITS-1:0] dv_q_r   [DV_STAGES+1][3];
  logic [NRM_W-1:0]   dv_d_r   [DV_STAGES+1];
  side_t              dv_sd_r  [DV_STAGES+1];
  logic               dv_vld_r [DV_STAGES+1];
  logic [NRM_W-1:0]   norm;

  assign norm = sq_r_r[SQ_STAGES][NRM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_vld_r[0] <= sq_vld_r[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_d_r[0]  <= norm;
      dv_sd_r[0] <= sq_sd_r[SQ_STAGES];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= REM_W'({sq_sd_r[SQ_STAGES].mag[i], 14'd0})
                          + REM_W'(norm >> 1);
        dv_q_r[0][i]   <= '0;
      end
    end
  end

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
    logic [REM_W-1:0]   rem_nxt [3];
    logic [DV_BITS-1:0] q_nxt [3];

    always_comb begin
      logic [REM_W-1:0] dsh;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = dv_rem_r[g][i];
        q_nxt[i]   = dv_q_r[g][i];
        for (int s = 0; s < DV_PER; s++) begin
          dsh = REM_W'(dv_d_r[g]) << (DV_BITS - 1 - (g * DV_PER + s));
          if (rem_nxt[i] >= dsh) begin
            rem_nxt[i] = rem_nxt[i] - dsh;
            q_nxt[i]   = q_nxt[i] | (DV_BITS'(1) << (DV_BITS - 1 - (g * DV_PER + s)));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[g+1] <= 1'b0;
      end else if (pipe_en) begin
        dv_vld_r[g+1] <= dv_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv_d_r[g+1]  <= dv_d_r[g];
        dv_sd_r[g+1] <= dv_sd_r[g];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[g+1][i] <= rem_nxt[i];
          dv_q_r[g+1][i]   <= q_nxt[i];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic      out_vld_r;
  out_item_t out_data_r;
  side_t     fsd;
  logic [15:0] nv [3];

  assign fsd = dv_sd_r[DV_STAGES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fsd.degen) begin
        nv[i] = '0;
      end else if (fsd.neg[i]) begin
        nv[i] = -dv_q_r[DV_STAGES][i];
      end else begin
        nv[i] = dv_q_r[DV_STAGES][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= dv_vld_r[DV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r.norm_x         <= nv[0];
      out_data_r.norm_y         <= nv[1];
      out_data_r.norm_z         <= nv[2];
      out_data_r.center_x       <= fsd.center[0];
      out_data_r.center_y       <= fsd.center[1];
      out_data_r.center_z       <= fsd.center[2];
      out_data_r.degenerate     <= fsd.degen;
      out_data_r.final_face_out <= fsd.final_face;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.norm_x == 16'd0 && out_data.norm_y == 16'd0 && out_data.norm_z == 16'd0)
    else $error("degenerate face with nonzero normal");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      $signed(out_data.norm_x) <= 16384 && $signed(out_data.norm_x) >= -16384 &&
      $signed(out_data.norm_y) <= 16384 && $signed(out_data.norm_y) >= -16384 &&
      $signed(out_data.norm_z) <= 16384 && $signed(out_data.norm_z) >= -16384)
    else $error("normal component out of range");

  a_write_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == CMD_WRITE |=> !s1_vld_r)
    else $error("vertex write entered the face pipeline");

endmodule
